// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CHK_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rttpto check failed");

// expression must keep its value over the cycle after cond
`define CHK_HOLD(lbl, clk, rst, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(expr)) \
    else $error("rttpto hold check failed");

`endif

// ===== rtl/rttpto_pkg.sv =====
// shared types and constants of the rtt estimator
`default_nettype none
package rttpto_pkg;

  // field widths
  localparam int RTT_W     = 24;
  localparam int DELAY_W   = 24;
  localparam int SHIFT_W   = 4;
  localparam int PTO_W     = 32;
  localparam int PMAD_W    = 14;

  // timer granularity in ms
  localparam int TIMER_GRANULARITY = 1;

  // spread = 4 * variance, then shifted by the backoff
  localparam int SPREAD_W  = RTT_W + 2;
  localparam int SHIFT_MAX = (1 << SHIFT_W) - 1;
  localparam int WIDE_W    = SPREAD_W + SHIFT_MAX + 2;

  localparam logic [SPREAD_W-1:0] GRAN = SPREAD_W'(TIMER_GRANULARITY);

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_PEER_MAX_ACK_DELAY = 1'b0;
  localparam logic [PMAD_W-1:0] PMAD_RESET = PMAD_W'(25);

  // estimator state handed to the timeout stage
  typedef struct packed {
    logic [RTT_W-1:0]   smoothed;
    logic [RTT_W-1:0]   variance;
    logic [RTT_W-1:0]   minimum;
    logic [RTT_W-1:0]   latest;
    logic [SHIFT_W-1:0] shift;
  } est_t;

endpackage
`default_nettype wire

// ===== rtl/rttpto_if.sv =====
// request channels of the rtt estimator: samples in, results out
`default_nettype none
interface rttpto_sample_if;
  logic                              valid;
  logic                              ready;
  logic [rttpto_pkg::RTT_W-1:0]      rtt_sample;
  logic [rttpto_pkg::DELAY_W-1:0]    reported_delay;
  logic [rttpto_pkg::SHIFT_W-1:0]    backoff_exponent;

  modport source (output valid, rtt_sample, reported_delay, backoff_exponent, input ready);
  modport sink (input valid, rtt_sample, reported_delay, backoff_exponent, output ready);
endinterface

interface rttpto_result_if;
  logic                          valid;
  logic                          ready;
  logic [rttpto_pkg::RTT_W-1:0]  smoothed_rtt_out;
  logic [rttpto_pkg::RTT_W-1:0]  rtt_variance_out;
  logic [rttpto_pkg::RTT_W-1:0]  min_rtt_out;
  logic [rttpto_pkg::RTT_W-1:0]  latest_rtt_out;
  logic [rttpto_pkg::PTO_W-1:0]  pto_base_duration;
  logic [rttpto_pkg::PTO_W-1:0]  pto_app_duration;

  modport source (output valid, smoothed_rtt_out, rtt_variance_out, min_rtt_out,
                  latest_rtt_out, pto_base_duration, pto_app_duration, input ready);
  modport sink (input valid, smoothed_rtt_out, rtt_variance_out, min_rtt_out,
                latest_rtt_out, pto_base_duration, pto_app_duration, output ready);
endinterface
`default_nettype wire

// ===== rtl/rttpto_apb.sv =====
// apb register block holding the peer max ack delay
`default_nettype none
module rttpto_apb (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [rttpto_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [rttpto_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [rttpto_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                      pready,
  output logic      [rttpto_pkg::PMAD_W-1:0]        peer_max_ack_delay
);

  logic reg_idx;
  logic wr_en;

  // register index is the word address
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && (reg_idx == rttpto_pkg::REG_PEER_MAX_ACK_DELAY);

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      peer_max_ack_delay <= rttpto_pkg::PMAD_RESET;
    end else if (wr_en) begin
      peer_max_ack_delay <= pwdata[rttpto_pkg::PMAD_W-1:0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (reg_idx == rttpto_pkg::REG_PEER_MAX_ACK_DELAY) begin
      prdata = rttpto_pkg::APB_DATA_W'(peer_max_ack_delay);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rttpto_update.sv =====
// input register, rtt state and filter update
`default_nettype none
module rttpto_update (
  input  wire logic          clk,
  input  wire logic          rst,
  rttpto_sample_if.sink      samples,
  output logic               est_valid,
  input  wire logic          est_ready,
  output rttpto_pkg::est_t   est
);

  localparam int W = rttpto_pkg::RTT_W;

  // estimator state
  logic [W-1:0] min_rtt;
  logic [W-1:0] smoothed_rtt;
  logic [W-1:0] rtt_variance;

  // input register
  logic                           s0_valid;
  logic [W-1:0]                   s0_sample;
  logic [rttpto_pkg::DELAY_W-1:0] s0_delay;
  logic [rttpto_pkg::SHIFT_W-1:0] s0_shift;

  logic s0_ready;
  logic s1_ready;
  logic advance;

  logic [W-1:0]   min_next;
  logic [W-1:0]   adj;
  logic [W-1:0]   diff;
  logic [W:0]     thresh;
  logic [W+2:0]   var_sum;
  logic [W+2:0]   srtt_sum;
  logic [W-1:0]   var_next;
  logic [W-1:0]   srtt_next;

  // stage handshakes
  assign s1_ready      = !est_valid || est_ready;
  assign s0_ready      = !s0_valid || s1_ready;
  assign samples.ready = s0_ready;
  assign advance       = s0_valid && s1_ready;

  // capture the incoming sample
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && s0_ready) begin
      s0_sample <= samples.rtt_sample;
      s0_delay  <= samples.reported_delay;
      s0_shift  <= samples.backoff_exponent;
    end
  end

  // filter update, seeding while the minimum is zero (no sample yet, or a zero sample)
  always_comb begin
    min_next  = min_rtt;
    adj       = s0_sample;
    diff      = '0;
    thresh    = '0;
    var_sum   = '0;
    srtt_sum  = '0;
    var_next  = '0;
    srtt_next = '0;
    if (min_rtt == '0) begin
      min_next  = s0_sample;
      srtt_next = s0_sample;
      var_next  = s0_sample >> 1;
    end else begin
      if (s0_sample < min_rtt) begin
        min_next = s0_sample;
      end
      // ack delay only subtracted when it leaves the sample at or above the minimum
      thresh = {1'b0, min_next} + {1'b0, s0_delay};
      if ((s0_delay != '0) && ({1'b0, s0_sample} >= thresh)) begin
        adj = s0_sample - s0_delay;
      end
      diff      = (smoothed_rtt >= adj) ? (smoothed_rtt - adj) : (adj - smoothed_rtt);
      var_sum   = (W+3)'({rtt_variance, 1'b0}) + (W+3)'(rtt_variance) + (W+3)'(diff);
      srtt_sum  = (W+3)'({smoothed_rtt, 3'b000}) - (W+3)'(smoothed_rtt) + (W+3)'(adj);
      var_next  = var_sum[W+1:2];
      srtt_next = srtt_sum[W+2:3];
    end
  end

  // state update as the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      min_rtt      <= '0;
      smoothed_rtt <= '0;
      rtt_variance <= '0;
    end else if (advance) begin
      min_rtt      <= min_next;
      smoothed_rtt <= srtt_next;
      rtt_variance <= var_next;
    end
  end

  // estimate register
  always_ff @(posedge clk) begin
    if (rst) begin
      est_valid <= 1'b0;
    end else if (s1_ready) begin
      est_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      est.smoothed <= srtt_next;
      est.variance <= var_next;
      est.minimum  <= min_next;
      est.latest   <= s0_sample;
      est.shift    <= s0_shift;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rttpto_pto.sv =====
// probe timeout durations and result register
`default_nettype none
module rttpto_pto (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               est_valid,
  output logic                                    est_ready,
  input  wire rttpto_pkg::est_t                   est,
  input  wire logic [rttpto_pkg::PMAD_W-1:0]      peer_max_ack_delay,
  rttpto_result_if.source                         results
);

  localparam int WW = rttpto_pkg::WIDE_W;
  localparam int PW = rttpto_pkg::PTO_W;

  logic                             out_valid;
  logic [rttpto_pkg::SPREAD_W-1:0]  spread;
  logic [WW-1:0]                    base;
  logic [WW-1:0]                    app;
  logic [PW-1:0]                    base_sat;
  logic [PW-1:0]                    app_sat;

  assign est_ready     = !out_valid || results.ready;
  assign results.valid = out_valid;

  // spread with granularity floor, then the shifted sums
  always_comb begin
    spread = {est.variance, 2'b00};
    if (spread < rttpto_pkg::GRAN) begin
      spread = rttpto_pkg::GRAN;
    end
    base = WW'(est.smoothed) + (WW'(spread) << est.shift);
    app  = base + (WW'(peer_max_ack_delay) << est.shift);
  end

  // saturate to 32 bits
  assign base_sat = (base[WW-1:PW] != '0) ? '1 : base[PW-1:0];
  assign app_sat  = (app[WW-1:PW] != '0) ? '1 : app[PW-1:0];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (est_ready) begin
      out_valid <= est_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (est_valid && est_ready) begin
      results.smoothed_rtt_out  <= est.smoothed;
      results.rtt_variance_out  <= est.variance;
      results.min_rtt_out       <= est.minimum;
      results.latest_rtt_out    <= est.latest;
      results.pto_base_duration <= base_sat;
      results.pto_app_duration  <= app_sat;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rtt_estimator_with_pto.sv =====
// top level of the quic rtt estimator with probe timeout durations
//
//   port group  | dir | contents
//   samples     | in  | rtt_sample, reported_delay, backoff_exponent (valid/ready)
//   results     | out | srtt, variance, min, latest, pto base and app (valid/ready)
//   apb (p*)    | in  | peer_max_ack_delay at byte address 0
//
// one sample per cycle sustained while results are taken; a result passes the input
// register, the filter update into the estimate register and the timeout sums into
// the result register. the filter state loops through its combinational update
// logic, so samples may follow each other in every cycle. reset clears the rtt state
// to zero (no sample yet) and sets peer_max_ack_delay to 25. a stalled result holds in
// its register while the earlier stages keep filling.
`default_nettype none
module rtt_estimator_with_pto (
  input  wire logic                               clk,
  input  wire logic                               rst,
  rttpto_sample_if.sink                           samples,
  rttpto_result_if.source                         results,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [rttpto_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [rttpto_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [rttpto_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                    pready
);

  logic [rttpto_pkg::PMAD_W-1:0] peer_max_ack_delay;
  logic                          est_valid;
  logic                          est_ready;
  rttpto_pkg::est_t              est;

  // configuration registers
  rttpto_apb u_apb (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .peer_max_ack_delay (peer_max_ack_delay)
  );

  // rtt filter
  rttpto_update u_update (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .est_valid (est_valid),
    .est_ready (est_ready),
    .est       (est)
  );

  // timeout durations
  rttpto_pto u_pto (
    .clk                (clk),
    .rst                (rst),
    .est_valid          (est_valid),
    .est_ready          (est_ready),
    .est                (est),
    .peer_max_ack_delay (peer_max_ack_delay),
    .results            (results)
  );

endmodule
`default_nettype wire

// ===== rtl/rttpto_checker.sv =====
// port-level checks of the rtt estimator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module rttpto_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             res_valid,
  input wire logic                             res_ready,
  input wire logic [rttpto_pkg::RTT_W-1:0]     min_rtt_out,
  input wire logic [rttpto_pkg::RTT_W-1:0]     latest_rtt_out,
  input wire logic [rttpto_pkg::RTT_W-1:0]     smoothed_rtt_out,
  input wire logic [rttpto_pkg::PTO_W-1:0]     pto_base_duration,
  input wire logic [rttpto_pkg::PTO_W-1:0]     pto_app_duration
);

  // stalled result keeps valid and its duration
  `CHK_ALWAYS(a_valid_hold, clk, rst, (res_valid && !res_ready) |=> res_valid)
  `CHK_HOLD(a_app_hold, clk, rst, res_valid && !res_ready, pto_app_duration)

  // minimum never above the sample just taken
  `CHK_ALWAYS(a_min_le_latest, clk, rst, res_valid |-> (min_rtt_out <= latest_rtt_out))

  // durations are ordered over smoothed rtt
  `CHK_ALWAYS(a_base_ge_srtt, clk, rst, res_valid |-> (pto_base_duration >= 32'(smoothed_rtt_out)))
  `CHK_ALWAYS(a_app_ge_base, clk, rst, res_valid |-> (pto_app_duration >= pto_base_duration))

endmodule

bind rtt_estimator_with_pto rttpto_checker u_rttpto_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (results.valid),
  .res_ready         (results.ready),
  .min_rtt_out       (results.min_rtt_out),
  .latest_rtt_out    (results.latest_rtt_out),
  .smoothed_rtt_out  (results.smoothed_rtt_out),
  .pto_base_duration (results.pto_base_duration),
  .pto_app_duration  (results.pto_app_duration)
);
`default_nettype wire

// ===== test/rttpto_checker.sv =====
`timescale 1ns / 100ps
// rtt estimator checker: predicts every result from the accepted samples and compares
module rttpto_scoreboard
  import rttpto_pkg::*;
#(
  parameter logic [APB_ADDR_W-1:0] PMAD_ADDR = '0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rttpto_sample_if                   samples,
  rttpto_result_if                   results,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output int                         mismatches,
  output int                         pending,
  output int                         checked,
  output int                         seeds
);

  typedef struct packed {
    logic [RTT_W-1:0] smoothed;
    logic [RTT_W-1:0] variance;
    logic [RTT_W-1:0] minimum;
    logic [RTT_W-1:0] latest;
    logic [PTO_W-1:0] base;
    logic [PTO_W-1:0] app;
  } rtt_estimate_t;

  // filter state and register copy of the predictor
  logic [RTT_W-1:0]  cur_latest;
  logic [RTT_W-1:0]  cur_min;
  logic [RTT_W-1:0]  cur_srtt;
  logic [RTT_W-1:0]  cur_var;
  logic [PMAD_W-1:0] peer_delay;

  rtt_estimate_t estimates_due[$];
  rtt_estimate_t want;

  // one filter step, updating the state and returning the new estimate
  function automatic rtt_estimate_t next_estimate(input logic [RTT_W-1:0] sample,
                                                  input logic [DELAY_W-1:0] delay,
                                                  input logic [SHIFT_W-1:0] shift);
    logic [RTT_W-1:0]    adj;
    logic [RTT_W-1:0]    diff;
    logic [SPREAD_W-1:0] spread;
    logic [63:0]         sum;
    logic [63:0]         base_w;
    logic [63:0]         app_w;
    rtt_estimate_t       est;
    cur_latest = sample;
    if (cur_min == '0) begin
      // empty filter: seed from this sample, delay ignored
      cur_srtt = sample;
      cur_var  = sample >> 1;
      cur_min  = sample;
    end else begin
      adj = sample;
      if (sample < cur_min) cur_min = sample;
      // delay only taken off when it keeps the sample at or above the minimum
      if (delay != '0 && {1'b0, sample} >= {1'b0, cur_min} + {1'b0, delay}) begin
        adj = sample - delay;
      end
      diff = (cur_srtt >= adj) ? cur_srtt - adj : adj - cur_srtt;
      // variance weighs 3/4 old, srtt weighs 7/8 old
      sum = 64'(cur_var) * 3 + 64'(diff);
      cur_var = RTT_W'(sum >> 2);
      sum = 64'(cur_srtt) * 7 + 64'(adj);
      cur_srtt = RTT_W'(sum >> 3);
    end
    // timeout durations at full width, then saturated
    spread = {cur_var, 2'b00};
    if (spread < GRAN) spread = GRAN;
    base_w = 64'(cur_srtt) + (64'(spread) << shift);
    app_w  = base_w + (64'(peer_delay) << shift);
    est.smoothed = cur_srtt;
    est.variance = cur_var;
    est.minimum  = cur_min;
    est.latest   = cur_latest;
    est.base     = (base_w > 64'(32'hFFFF_FFFF)) ? '1 : PTO_W'(base_w);
    est.app      = (app_w > 64'(32'hFFFF_FFFF)) ? '1 : PTO_W'(app_w);
    return est;
  endfunction

  function automatic void compare_field(input string field, input logic [PTO_W-1:0] expected,
                                        input logic [PTO_W-1:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, got %0d", field, expected, actual);
      mismatches++;
    end
  endfunction

  // watch results, samples and register writes at each edge
  always @(posedge clk) begin
    if (rst) begin
      cur_latest = '0;
      cur_min    = '0;
      cur_srtt   = '0;
      cur_var    = '0;
      peer_delay = PMAD_RESET;
      estimates_due.delete();
    end else begin
      if (results.valid && results.ready) begin
        if (estimates_due.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = estimates_due.pop_front();
          compare_field("smoothed_rtt_out", PTO_W'(want.smoothed), PTO_W'(results.smoothed_rtt_out));
          compare_field("rtt_variance_out", PTO_W'(want.variance), PTO_W'(results.rtt_variance_out));
          compare_field("min_rtt_out", PTO_W'(want.minimum), PTO_W'(results.min_rtt_out));
          compare_field("latest_rtt_out", PTO_W'(want.latest), PTO_W'(results.latest_rtt_out));
          compare_field("pto_base_duration", want.base, results.pto_base_duration);
          compare_field("pto_app_duration", want.app, results.pto_app_duration);
          checked++;
        end
      end
      if (samples.valid && samples.ready) begin
        if (cur_min == '0) seeds++;
        estimates_due.push_back(next_estimate(samples.rtt_sample, samples.reported_delay,
                                              samples.backoff_exponent));
      end
      if (psel && penable && pwrite && pready && paddr == PMAD_ADDR) begin
        peer_delay = pwdata[PMAD_W-1:0];
      end
    end
    pending = estimates_due.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// rtt estimator testbench top: clock, reset, stimulus, register writes and verdict
module testbench;
  import rttpto_pkg::*;

  localparam logic [APB_ADDR_W-1:0] PMAD_ADDR = APB_ADDR_W'(4 * REG_PEER_MAX_ACK_DELAY);
  localparam int HOLD_CYCLES     = 150;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int SETTLE_CYCLES   = 12;
  localparam int GAP_MAX         = 18;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int pending;
  int checked;
  int seeds;
  int send_gap_max;
  int recv_gap_max;
  int samples_sent;
  bit hold_request;

  rttpto_sample_if sample_ch();
  rttpto_result_if result_ch();

  rtt_estimator_with_pto uut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rttpto_scoreboard #(
    .PMAD_ADDR (PMAD_ADDR)
  ) rtt_check (
    .clk        (clk),
    .rst        (rst),
    .samples    (sample_ch),
    .results    (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .seeds      (seeds)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // offer one sample after a random gap, return once it is taken
  task automatic send_sample(input logic [RTT_W-1:0] rtt, input logic [DELAY_W-1:0] delay,
                             input logic [SHIFT_W-1:0] shift);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid            <= 1'b1;
    sample_ch.rtt_sample       <= rtt;
    sample_ch.reported_delay   <= delay;
    sample_ch.backoff_exponent <= shift;
    do @(posedge clk); while (!sample_ch.ready);
    samples_sent++;
  endtask

  // random samples, mostly near realistic rtts, with idle-free stretches
  task automatic run_phase(input int count);
    logic [RTT_W-1:0]   rtt;
    logic [DELAY_W-1:0] delay;
    logic [SHIFT_W-1:0] shift;
    for (int k = 0; k < count; k++) begin
      send_gap_max = ((k / 24) % 4 == 3) ? 0 : GAP_MAX;
      recv_gap_max = ((k / 20) % 5 == 2) ? 0 : GAP_MAX;
      case ($urandom_range(0, 19))
        0:       rtt = '0;
        1, 2:    rtt = RTT_W'($urandom);
        3:       rtt = {RTT_W{1'b1}} - RTT_W'($urandom_range(0, 15));
        default: rtt = RTT_W'($urandom_range(1, 3000));
      endcase
      case ($urandom_range(0, 5))
        0:       delay = '0;
        1:       delay = DELAY_W'($urandom);
        2:       delay = DELAY_W'($urandom_range(0, rtt));
        default: delay = DELAY_W'($urandom_range(0, 400));
      endcase
      shift = SHIFT_W'($urandom_range(0, SHIFT_MAX));
      send_sample(rtt, delay, shift);
    end
    send_gap_max = GAP_MAX;
    recv_gap_max = GAP_MAX;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain;
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // register write: setup then access
  task automatic write_peer_delay(input logic [PMAD_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PMAD_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result side: random stall per result, one long hold-off on request
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = $urandom_range(0, recv_gap_max);
      end
      @(negedge clk);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // main sequence
  initial begin
    rst                        = 1'b1;
    psel                       = 1'b0;
    penable                    = 1'b0;
    pwrite                     = 1'b0;
    paddr                      = '0;
    pwdata                     = '0;
    sample_ch.valid            = 1'b0;
    sample_ch.rtt_sample       = '0;
    sample_ch.reported_delay   = '0;
    sample_ch.backoff_exponent = '0;
    hold_request               = 1'b0;
    send_gap_max               = GAP_MAX;
    recv_gap_max               = GAP_MAX;
    samples_sent               = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset register value, filter starting empty
    send_sample(24'd0, 24'd5, 4'd0);               // zero sample, no history
    send_sample(24'd0, 24'hFFFFFF, 4'd15);         // still no history
    send_sample(24'd100, 24'd50, 4'd0);            // seeds, delay ignored
    send_sample(24'd60, 24'd0, 4'd1);              // new minimum
    send_sample(24'd200, 24'd100, 4'd2);           // delay taken off
    send_sample(24'd100, 24'd50, 4'd3);            // delay kept
    send_sample(24'd160, 24'd100, 4'd4);           // exactly min + delay
    send_sample(24'hFFFFFF, 24'hFFFFFF, 4'd15);    // sum past 24 bits
    send_sample(24'hFFFFFF, 24'd1, 4'd15);
    send_sample(24'hFFFFFF, 24'd0, 4'd15);         // saturating durations
    send_sample(24'd0, 24'd0, 4'd0);               // zero sample clears minimum
    send_sample(24'd1, 24'd0, 4'd0);               // reseed, variance at granularity
    send_sample(24'd1, 24'd1, 4'd8);
    send_sample(24'hAAAAAA, 24'h555555, 4'd10);
    send_sample(24'h555555, 24'hAAAAAA, 4'd5);
    send_sample(24'd2, 24'd1, 4'd0);
    send_sample(24'd1, 24'd0, 4'd0);
    send_sample(24'd3000, 24'd2999, 4'd7);
    drain();

    write_peer_delay('0);
    run_phase(ITEMS_PER_PHASE);
    drain();

    // largest register value, with a long result hold-off to back up the input
    write_peer_delay('1);
    hold_request = 1'b1;
    run_phase(ITEMS_PER_PHASE);
    drain();

    write_peer_delay(PMAD_W'($urandom));
    run_phase(ITEMS_PER_PHASE);
    drain();

    write_peer_delay(PMAD_W'($urandom_range(1, 200)));
    run_phase(ITEMS_PER_PHASE);
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d samples, %0d results checked, %0d of them seeding the filter",
             samples_sent, checked, seeds);
    $display("peer ack delay at reset, zero, full scale and random; one %0d-cycle output stall",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rttpto_pkg.sv
rtl/rttpto_if.sv
rtl/rttpto_apb.sv
rtl/rttpto_update.sv
rtl/rttpto_pto.sv
rtl/rtt_estimator_with_pto.sv
rtl/rttpto_checker.sv
test/rttpto_checker.sv
test/testbench.sv
